FILE: rtl/vvf_pkg.sv
// shared constants, types and address helpers for the voxel visible face finder
package vvf_pkg;

    // volume geometry and stored type width
    localparam int EDGE      = 32;
    localparam int TYPE_BITS = 8;

    // fixed field widths of the ports
    localparam int COORD_W = 5;
    localparam int DIR_W   = 3;
    localparam int KIND_W  = 8;
    localparam int ACT_W   = 2;
    localparam int CFG_W   = 8;
    localparam int PRES_W  = 6;

    // address widths of the two stores
    localparam int AXIS_W = (EDGE > 1) ? $clog2(EDGE) : 1;
    localparam int VOX_AW = 3 * AXIS_W;
    localparam int PLN_AW = DIR_W + 2 * AXIS_W;

    // request codes
    localparam logic [ACT_W-1:0] ACT_WR_VOXEL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_PLANE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd2;

    // face directions in scan order
    localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd0;
    localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd2;
    localparam logic [DIR_W-1:0] DIR_POS_X = 3'd3;
    localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd4;
    localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd5;

    // configuration register indexes
    localparam logic CFG_PRESENT = 1'b0;
    localparam logic CFG_AIR     = 1'b1;

    typedef struct packed {
        logic                 en;
        logic [VOX_AW-1:0]    addr;
        logic [TYPE_BITS-1:0] data;
    } vox_wr_t;

    typedef struct packed {
        logic                 en;
        logic [PLN_AW-1:0]    addr;
        logic [TYPE_BITS-1:0] data;
    } pln_wr_t;

    // one direction step of a query, passed from the sequencer to the evaluator
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [DIR_W-1:0]   dir;
        logic               on_edge;
        logic               first;
        logic               last;
    } step_t;

    function automatic logic in_range(input logic [COORD_W-1:0] c);
        return (32'(c) < EDGE);
    endfunction

    function automatic logic at_top(input logic [COORD_W-1:0] c);
        return (32'(c) == EDGE - 1);
    endfunction

    function automatic logic [VOX_AW-1:0] vox_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
        return {AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)};
    endfunction

    // planes -y/+y use (x,z), -x/+x use (y,z), -z/+z use (x,y)
    function automatic logic [PLN_AW-1:0] plane_addr(input logic [DIR_W-1:0]   d,
                                                     input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y,
                                                     input logic [COORD_W-1:0] z);
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        if (d < DIR_NEG_X) begin
            a = x;
            b = z;
        end else if (d < DIR_NEG_Z) begin
            a = y;
            b = z;
        end else begin
            a = x;
            b = y;
        end
        return {d, AXIS_W'(b), AXIS_W'(a)};
    endfunction

endpackage

FILE: rtl/vvf_voxel_ram.sv
// voxel store: one write port, two registered read ports
module vvf_voxel_ram (
    input  logic                           aclk,
    input  vvf_pkg::vox_wr_t               wr,
    input  logic                           a_en,
    input  logic [vvf_pkg::VOX_AW-1:0]     a_addr,
    output logic [vvf_pkg::TYPE_BITS-1:0]  a_data,
    input  logic                           b_en,
    input  logic [vvf_pkg::VOX_AW-1:0]     b_addr,
    output logic [vvf_pkg::TYPE_BITS-1:0]  b_data
);

    logic [vvf_pkg::TYPE_BITS-1:0] mem [2**vvf_pkg::VOX_AW];
    logic [vvf_pkg::TYPE_BITS-1:0] a_data_reg;
    logic [vvf_pkg::TYPE_BITS-1:0] b_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (a_en) begin
            a_data_reg <= mem[a_addr];
        end
        if (b_en) begin
            b_data_reg <= mem[b_addr];
        end
    end

    assign a_data = a_data_reg;
    assign b_data = b_data_reg;

endmodule

FILE: rtl/vvf_plane_ram.sv
// neighbor plane store: one write port, one registered read port
module vvf_plane_ram (
    input  logic                           aclk,
    input  vvf_pkg::pln_wr_t               wr,
    input  logic                           rd_en,
    input  logic [vvf_pkg::PLN_AW-1:0]     rd_addr,
    output logic [vvf_pkg::TYPE_BITS-1:0]  rd_data
);

    logic [vvf_pkg::TYPE_BITS-1:0] mem [2**vvf_pkg::PLN_AW];
    logic [vvf_pkg::TYPE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/vvf_sequencer.sv
// request decode, store writes and per-direction read issue for queries
module vvf_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vvf_pkg::ACT_W-1:0]         s_action,
    input  logic [vvf_pkg::COORD_W-1:0]       s_pos_x,
    input  logic [vvf_pkg::COORD_W-1:0]       s_pos_y,
    input  logic [vvf_pkg::COORD_W-1:0]       s_pos_z,
    input  logic [vvf_pkg::DIR_W-1:0]         s_plane_dir,
    input  logic [vvf_pkg::KIND_W-1:0]        s_block_kind,
    input  logic                              advance,
    output vvf_pkg::vox_wr_t                  vox_wr,
    output vvf_pkg::pln_wr_t                  pln_wr,
    output logic                              nbr_en,
    output logic [vvf_pkg::VOX_AW-1:0]        nbr_addr,
    output logic                              ctr_en,
    output logic [vvf_pkg::VOX_AW-1:0]        ctr_addr,
    output logic [vvf_pkg::PLN_AW-1:0]        pln_addr,
    output logic                              step_valid,
    output vvf_pkg::step_t                    step
);

    logic                          busy_reg;
    logic [vvf_pkg::DIR_W-1:0]     dir_reg;
    logic [vvf_pkg::COORD_W-1:0]   x_reg;
    logic [vvf_pkg::COORD_W-1:0]   y_reg;
    logic [vvf_pkg::COORD_W-1:0]   z_reg;

    logic                          accept;
    logic                          last_step;
    logic                          query_load;
    logic                          plane_ok;
    logic [vvf_pkg::COORD_W-1:0]   nx;
    logic [vvf_pkg::COORD_W-1:0]   ny;
    logic [vvf_pkg::COORD_W-1:0]   nz;
    logic                          on_edge;

    assign last_step = (dir_reg == vvf_pkg::DIR_POS_Z);
    assign s_ready   = !busy_reg || (last_step && advance);
    assign accept    = s_valid && s_ready;

    assign query_load = accept && (s_action == vvf_pkg::ACT_QUERY) &&
                        vvf_pkg::in_range(s_pos_x) && vvf_pkg::in_range(s_pos_y) &&
                        vvf_pkg::in_range(s_pos_z);

    // the plane's own axis is not checked and does not enter the plane address
    always_comb begin
        if (s_plane_dir < vvf_pkg::DIR_NEG_X) begin
            plane_ok = vvf_pkg::in_range(s_pos_x) && vvf_pkg::in_range(s_pos_z);
        end else if (s_plane_dir < vvf_pkg::DIR_NEG_Z) begin
            plane_ok = vvf_pkg::in_range(s_pos_y) && vvf_pkg::in_range(s_pos_z);
        end else if (s_plane_dir <= vvf_pkg::DIR_POS_Z) begin
            plane_ok = vvf_pkg::in_range(s_pos_x) && vvf_pkg::in_range(s_pos_y);
        end else begin
            plane_ok = 1'b0;
        end
    end

    // writes land at the accept edge; an older query's last read at that edge sees old data
    always_comb begin
        vox_wr.en   = accept && (s_action == vvf_pkg::ACT_WR_VOXEL) &&
                      vvf_pkg::in_range(s_pos_x) && vvf_pkg::in_range(s_pos_y) &&
                      vvf_pkg::in_range(s_pos_z);
        vox_wr.addr = vvf_pkg::vox_addr(s_pos_x, s_pos_y, s_pos_z);
        vox_wr.data = vvf_pkg::TYPE_BITS'(s_block_kind);
        pln_wr.en   = accept && (s_action == vvf_pkg::ACT_WR_PLANE) && plane_ok;
        pln_wr.addr = vvf_pkg::plane_addr(s_plane_dir, s_pos_x, s_pos_y, s_pos_z);
        pln_wr.data = vvf_pkg::TYPE_BITS'(s_block_kind);
    end

    always_comb begin
        nx      = x_reg;
        ny      = y_reg;
        nz      = z_reg;
        on_edge = 1'b1;
        unique case (dir_reg)
            vvf_pkg::DIR_NEG_Y: begin
                on_edge = (y_reg == '0);
                ny      = y_reg - vvf_pkg::COORD_W'(1);
            end
            vvf_pkg::DIR_POS_Y: begin
                on_edge = vvf_pkg::at_top(y_reg);
                ny      = y_reg + vvf_pkg::COORD_W'(1);
            end
            vvf_pkg::DIR_NEG_X: begin
                on_edge = (x_reg == '0);
                nx      = x_reg - vvf_pkg::COORD_W'(1);
            end
            vvf_pkg::DIR_POS_X: begin
                on_edge = vvf_pkg::at_top(x_reg);
                nx      = x_reg + vvf_pkg::COORD_W'(1);
            end
            vvf_pkg::DIR_NEG_Z: begin
                on_edge = (z_reg == '0);
                nz      = z_reg - vvf_pkg::COORD_W'(1);
            end
            vvf_pkg::DIR_POS_Z: begin
                on_edge = vvf_pkg::at_top(z_reg);
                nz      = z_reg + vvf_pkg::COORD_W'(1);
            end
            default: begin
                on_edge = 1'b1;
            end
        endcase
    end

    assign step_valid = busy_reg && advance;
    assign nbr_en     = step_valid;
    assign nbr_addr   = vvf_pkg::vox_addr(nx, ny, nz);
    assign pln_addr   = vvf_pkg::plane_addr(dir_reg, x_reg, y_reg, z_reg);
    // center voxel read rides along with the first direction
    assign ctr_en     = step_valid && (dir_reg == vvf_pkg::DIR_NEG_Y);
    assign ctr_addr   = vvf_pkg::vox_addr(x_reg, y_reg, z_reg);

    always_comb begin
        step.x       = x_reg;
        step.y       = y_reg;
        step.z       = z_reg;
        step.dir     = dir_reg;
        step.on_edge = on_edge;
        step.first   = (dir_reg == vvf_pkg::DIR_NEG_Y);
        step.last    = last_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            dir_reg  <= vvf_pkg::DIR_NEG_Y;
        end else begin
            if (busy_reg && advance) begin
                if (last_step) begin
                    busy_reg <= 1'b0;
                end else begin
                    dir_reg <= dir_reg + vvf_pkg::DIR_W'(1);
                end
            end
            if (query_load) begin
                busy_reg <= 1'b1;
                dir_reg  <= vvf_pkg::DIR_NEG_Y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (query_load) begin
            x_reg <= s_pos_x;
            y_reg <= s_pos_y;
            z_reg <= s_pos_z;
        end
    end

endmodule

FILE: rtl/vvf_face_eval.sv
// face test per direction, one-face hold for the last mark, and output register
module vvf_face_eval (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_valid,
    input  vvf_pkg::step_t                    step,
    input  logic [vvf_pkg::TYPE_BITS-1:0]     nbr_data,
    input  logic [vvf_pkg::TYPE_BITS-1:0]     ctr_data,
    input  logic [vvf_pkg::TYPE_BITS-1:0]     pln_data,
    input  logic [vvf_pkg::PRES_W-1:0]        neighbor_present,
    input  logic [vvf_pkg::CFG_W-1:0]         air_code,
    output logic                              advance,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vvf_pkg::COORD_W-1:0]       m_face_x,
    output logic [vvf_pkg::COORD_W-1:0]       m_face_y,
    output logic [vvf_pkg::COORD_W-1:0]       m_face_z,
    output logic [vvf_pkg::DIR_W-1:0]         m_face_dir,
    output logic [vvf_pkg::KIND_W-1:0]        m_facing_kind,
    output logic                              m_last_face
);

    vvf_pkg::step_t                 st_reg;
    logic                           st_valid_reg;
    logic                           ctr_air_reg;

    logic                           pend_valid_reg;
    logic                           pend_final_reg;
    vvf_pkg::step_t                 pend_reg;
    logic [vvf_pkg::TYPE_BITS-1:0]  pend_kind_reg;

    logic                           m_valid_reg;
    logic [vvf_pkg::COORD_W-1:0]    m_x_reg;
    logic [vvf_pkg::COORD_W-1:0]    m_y_reg;
    logic [vvf_pkg::COORD_W-1:0]    m_z_reg;
    logic [vvf_pkg::DIR_W-1:0]      m_dir_reg;
    logic [vvf_pkg::KIND_W-1:0]     m_kind_reg;
    logic                           m_last_reg;

    logic [vvf_pkg::TYPE_BITS-1:0]  air;
    logic [vvf_pkg::TYPE_BITS-1:0]  adj;
    logic                           ctr_is_air;
    logic                           ctr_air_now;
    logic                           dir_ok;
    logic                           visible;
    logic                           push;

    assign advance     = !m_valid_reg || m_ready;
    assign air         = vvf_pkg::TYPE_BITS'(air_code);
    assign adj         = st_reg.on_edge ? pln_data : nbr_data;
    assign ctr_is_air  = (ctr_data == air);
    assign ctr_air_now = st_reg.first ? ctr_is_air : ctr_air_reg;
    assign dir_ok      = !st_reg.on_edge || neighbor_present[st_reg.dir];
    assign visible     = st_valid_reg && ctr_air_now && dir_ok && (adj != air);
    // a held face leaves once the next face or the end of its query is known
    assign push        = pend_valid_reg && (pend_final_reg || visible);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else if (advance) begin
            st_valid_reg <= step_valid;
            m_valid_reg  <= push;
            if (visible) begin
                pend_valid_reg <= 1'b1;
                pend_final_reg <= st_reg.last;
            end else if (pend_valid_reg && !pend_final_reg) begin
                pend_final_reg <= st_valid_reg && st_reg.last;
            end else begin
                pend_valid_reg <= 1'b0;
                pend_final_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st_reg <= step;
            if (st_valid_reg && st_reg.first) begin
                ctr_air_reg <= ctr_is_air;
            end
            if (visible) begin
                pend_reg      <= st_reg;
                pend_kind_reg <= adj;
            end
            if (push) begin
                m_x_reg    <= pend_reg.x;
                m_y_reg    <= pend_reg.y;
                m_z_reg    <= pend_reg.z;
                m_dir_reg  <= pend_reg.dir;
                m_kind_reg <= vvf_pkg::KIND_W'(pend_kind_reg);
                m_last_reg <= pend_final_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_face_x      = m_x_reg;
    assign m_face_y      = m_y_reg;
    assign m_face_z      = m_z_reg;
    assign m_face_dir    = m_dir_reg;
    assign m_facing_kind = m_kind_reg;
    assign m_last_face   = m_last_reg;

endmodule

FILE: rtl/voxel_visible_face_finder.sv
// Visible face finder: a query on an air voxel checks its six neighbors (in the order
// -y,+y,-x,+x,-z,+z) and returns one result per opaque neighbor, the final one marked by
// m_last_face; at the volume border the neighbor comes from that side's plane store, and only
// if the side is marked present. A query holds the read sequencer for one direction per
// cycle while the output does not stall, on the voxel store's neighbor port and the plane
// store's port (the center voxel is read on the second voxel port with the first direction);
// the next request is taken as its last read goes out, and voxel and plane writes may come in
// that same cycle. A result passes the read data and step registers, the hold register, where
// a face waits until the next face or its query's end is known, and the output register.
// Neither store is cleared at reset: an entry reads back only what was written to it.
module voxel_visible_face_finder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [vvf_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vvf_pkg::ACT_W-1:0]         s_action,
    input  logic [vvf_pkg::COORD_W-1:0]       s_pos_x,
    input  logic [vvf_pkg::COORD_W-1:0]       s_pos_y,
    input  logic [vvf_pkg::COORD_W-1:0]       s_pos_z,
    input  logic [vvf_pkg::DIR_W-1:0]         s_plane_dir,
    input  logic [vvf_pkg::KIND_W-1:0]        s_block_kind,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vvf_pkg::COORD_W-1:0]       m_face_x,
    output logic [vvf_pkg::COORD_W-1:0]       m_face_y,
    output logic [vvf_pkg::COORD_W-1:0]       m_face_z,
    output logic [vvf_pkg::DIR_W-1:0]         m_face_dir,
    output logic [vvf_pkg::KIND_W-1:0]        m_facing_kind,
    output logic                              m_last_face
);

    logic [vvf_pkg::PRES_W-1:0]     present_reg;
    logic [vvf_pkg::CFG_W-1:0]      air_reg;

    logic                           advance;
    vvf_pkg::vox_wr_t               vox_wr;
    vvf_pkg::pln_wr_t               pln_wr;
    logic                           nbr_en;
    logic [vvf_pkg::VOX_AW-1:0]     nbr_addr;
    logic [vvf_pkg::TYPE_BITS-1:0]  nbr_data;
    logic                           ctr_en;
    logic [vvf_pkg::VOX_AW-1:0]     ctr_addr;
    logic [vvf_pkg::TYPE_BITS-1:0]  ctr_data;
    logic [vvf_pkg::PLN_AW-1:0]     pln_addr;
    logic [vvf_pkg::TYPE_BITS-1:0]  pln_data;
    logic                           step_valid;
    vvf_pkg::step_t                 step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            air_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vvf_pkg::CFG_PRESENT: present_reg <= vvf_pkg::PRES_W'(cfg_data);
                vvf_pkg::CFG_AIR:     air_reg     <= cfg_data;
                default:              air_reg     <= air_reg;
            endcase
        end
    end

    vvf_sequencer u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_plane_dir  (s_plane_dir),
        .s_block_kind (s_block_kind),
        .advance      (advance),
        .vox_wr       (vox_wr),
        .pln_wr       (pln_wr),
        .nbr_en       (nbr_en),
        .nbr_addr     (nbr_addr),
        .ctr_en       (ctr_en),
        .ctr_addr     (ctr_addr),
        .pln_addr     (pln_addr),
        .step_valid   (step_valid),
        .step         (step)
    );

    vvf_voxel_ram u_voxels (
        .aclk   (aclk),
        .wr     (vox_wr),
        .a_en   (nbr_en),
        .a_addr (nbr_addr),
        .a_data (nbr_data),
        .b_en   (ctr_en),
        .b_addr (ctr_addr),
        .b_data (ctr_data)
    );

    vvf_plane_ram u_planes (
        .aclk    (aclk),
        .wr      (pln_wr),
        .rd_en   (nbr_en),
        .rd_addr (pln_addr),
        .rd_data (pln_data)
    );

    vvf_face_eval u_eval (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_valid       (step_valid),
        .step             (step),
        .nbr_data         (nbr_data),
        .ctr_data         (ctr_data),
        .pln_data         (pln_data),
        .neighbor_present (present_reg),
        .air_code         (air_reg),
        .advance          (advance),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_face_x         (m_face_x),
        .m_face_y         (m_face_y),
        .m_face_z         (m_face_z),
        .m_face_dir       (m_face_dir),
        .m_facing_kind    (m_facing_kind),
        .m_last_face      (m_last_face)
    );

endmodule

FILE: rtl/vvf_checker.sv
// port-level checks for the voxel visible face finder, bound to the top level
module vvf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [vvf_pkg::COORD_W-1:0]   m_face_x,
    input logic [vvf_pkg::COORD_W-1:0]   m_face_y,
    input logic [vvf_pkg::COORD_W-1:0]   m_face_z,
    input logic [vvf_pkg::DIR_W-1:0]     m_face_dir,
    input logic [vvf_pkg::KIND_W-1:0]    m_facing_kind,
    input logic                          m_last_face
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_face_x) && $stable(m_face_y) &&
        $stable(m_face_z) && $stable(m_face_dir) && $stable(m_facing_kind) &&
        $stable(m_last_face))
        else $error("result changed while stalled");

    // +z is scanned last, so a +z face always closes its query
    a_posz_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_face_dir == vvf_pkg::DIR_POS_Z) |-> m_last_face)
        else $error("+z face without last mark");

    // faces only come in the six scan directions
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_face_dir <= vvf_pkg::DIR_POS_Z))
        else $error("face direction out of range");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind voxel_visible_face_finder vvf_checker u_vvf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_face_x      (m_face_x),
    .m_face_y      (m_face_y),
    .m_face_z      (m_face_z),
    .m_face_dir    (m_face_dir),
    .m_facing_kind (m_facing_kind),
    .m_last_face   (m_last_face)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the voxel visible face finder: directed and random requests
module testbench;

    localparam int VOX_DEPTH    = vvf_pkg::EDGE * vvf_pkg::EDGE * vvf_pkg::EDGE;
    localparam int PLANE_DEPTH  = 6 * vvf_pkg::EDGE * vvf_pkg::EDGE;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [vvf_pkg::ACT_W-1:0] ACT_UNUSED       = 2'd3;
    localparam logic [vvf_pkg::DIR_W-1:0] PLANE_SEL_BAD_LO = 3'd6;
    localparam logic [vvf_pkg::DIR_W-1:0] PLANE_SEL_BAD_HI = 3'd7;

    typedef struct packed {
        logic [vvf_pkg::COORD_W-1:0] x;
        logic [vvf_pkg::COORD_W-1:0] y;
        logic [vvf_pkg::COORD_W-1:0] z;
        logic [vvf_pkg::DIR_W-1:0]   dir;
        logic [vvf_pkg::KIND_W-1:0]  kind;
        logic                        last;
    } face_t;

    typedef logic [3*vvf_pkg::COORD_W-1:0] spot_t;

    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         cfg_we       = 1'b0;
    logic                         cfg_index    = vvf_pkg::CFG_PRESENT;
    logic [vvf_pkg::CFG_W-1:0]    cfg_data     = '0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [vvf_pkg::ACT_W-1:0]    s_action     = vvf_pkg::ACT_WR_VOXEL;
    logic [vvf_pkg::COORD_W-1:0]  s_pos_x      = '0;
    logic [vvf_pkg::COORD_W-1:0]  s_pos_y      = '0;
    logic [vvf_pkg::COORD_W-1:0]  s_pos_z      = '0;
    logic [vvf_pkg::DIR_W-1:0]    s_plane_dir  = '0;
    logic [vvf_pkg::KIND_W-1:0]   s_block_kind = '0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [vvf_pkg::COORD_W-1:0]  m_face_x;
    logic [vvf_pkg::COORD_W-1:0]  m_face_y;
    logic [vvf_pkg::COORD_W-1:0]  m_face_z;
    logic [vvf_pkg::DIR_W-1:0]    m_face_dir;
    logic [vvf_pkg::KIND_W-1:0]   m_facing_kind;
    logic                         m_last_face;

    // mirror of the block state
    logic [vvf_pkg::KIND_W-1:0]   voxel_copy [VOX_DEPTH];
    logic [vvf_pkg::KIND_W-1:0]   plane_copy [PLANE_DEPTH];
    bit                           vox_written [VOX_DEPTH];
    bit                           plane_written [PLANE_DEPTH];
    logic [vvf_pkg::PRES_W-1:0]   present_copy = '0;
    logic [vvf_pkg::KIND_W-1:0]   air_copy     = '0;

    face_t                    pending_faces [$];
    spot_t                    safe_spots [$];
    int                       fail_count    = 0;
    int                       sent_count    = 0;
    bit                       send_idle     = 1'b0;
    bit                       recv_idle     = 1'b0;
    int                       hold_requests = 0;
    int                       hold_served   = 0;
    int                       hold_left     = 0;
    int                       stall_left    = 0;

    voxel_visible_face_finder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_plane_dir   (s_plane_dir),
        .s_block_kind  (s_block_kind),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_face_x      (m_face_x),
        .m_face_y      (m_face_y),
        .m_face_z      (m_face_z),
        .m_face_dir    (m_face_dir),
        .m_facing_kind (m_facing_kind),
        .m_last_face   (m_last_face)
    );

    always #4 aclk = ~aclk;

    function automatic int vox_slot(input logic [vvf_pkg::COORD_W-1:0] x, y, z);
        return int'(x) + vvf_pkg::EDGE * int'(y) + vvf_pkg::EDGE * vvf_pkg::EDGE * int'(z);
    endfunction

    function automatic int plane_slot(input int d, input logic [vvf_pkg::COORD_W-1:0] x, y, z);
        int a;
        int b;
        if (d < 2) begin
            a = int'(x);
            b = int'(z);
        end else if (d < 4) begin
            a = int'(y);
            b = int'(z);
        end else begin
            a = int'(x);
            b = int'(y);
        end
        return d * vvf_pkg::EDGE * vvf_pkg::EDGE + a + vvf_pkg::EDGE * b;
    endfunction

    function automatic int axis_of(input int d);
        return (d < 2) ? 1 : (d < 4) ? 0 : 2;
    endfunction

    // one step in direction d, wrapping around the volume
    function automatic spot_t neighbor_of(input int d, input logic [vvf_pkg::COORD_W-1:0] x, y, z);
        logic [vvf_pkg::COORD_W-1:0] p [3];
        p[0] = x;
        p[1] = y;
        p[2] = z;
        if (d % 2) p[axis_of(d)] = p[axis_of(d)] + vvf_pkg::COORD_W'(1);
        else p[axis_of(d)] = p[axis_of(d)] - vvf_pkg::COORD_W'(1);
        return {p[2], p[1], p[0]};
    endfunction

    function automatic bit on_border(input int d, input logic [vvf_pkg::COORD_W-1:0] x, y, z);
        logic [vvf_pkg::COORD_W-1:0] p [3];
        p[0] = x;
        p[1] = y;
        p[2] = z;
        return (d % 2) ? (int'(p[axis_of(d)]) == vvf_pkg::EDGE - 1) : (p[axis_of(d)] == '0);
    endfunction

    // updates the mirror for one accepted request and queues the faces it should produce
    function automatic void track_request(input logic [vvf_pkg::ACT_W-1:0] act,
                                          input logic [vvf_pkg::COORD_W-1:0] x, y, z,
                                          input logic [vvf_pkg::DIR_W-1:0] pd,
                                          input logic [vvf_pkg::KIND_W-1:0] kind);
        face_t                       found [$];
        face_t                       f;
        logic [vvf_pkg::COORD_W-1:0] nx;
        logic [vvf_pkg::COORD_W-1:0] ny;
        logic [vvf_pkg::COORD_W-1:0] nz;
        logic [vvf_pkg::KIND_W-1:0]  adj;
        case (act)
            vvf_pkg::ACT_WR_VOXEL: begin
                voxel_copy[vox_slot(x, y, z)]  = kind;
                vox_written[vox_slot(x, y, z)] = 1'b1;
            end
            vvf_pkg::ACT_WR_PLANE: begin
                if (pd <= vvf_pkg::DIR_POS_Z) begin
                    plane_copy[plane_slot(int'(pd), x, y, z)]    = kind;
                    plane_written[plane_slot(int'(pd), x, y, z)] = 1'b1;
                end
            end
            vvf_pkg::ACT_QUERY: begin
                if (voxel_copy[vox_slot(x, y, z)] == air_copy) begin
                    for (int d = 0; d < 6; d++) begin
                        if (!on_border(d, x, y, z)) begin
                            {nz, ny, nx} = neighbor_of(d, x, y, z);
                            adj = voxel_copy[vox_slot(nx, ny, nz)];
                        end else if (present_copy[d]) begin
                            adj = plane_copy[plane_slot(d, x, y, z)];
                        end else begin
                            continue;
                        end
                        if (adj != air_copy) begin
                            f.x    = x;
                            f.y    = y;
                            f.z    = z;
                            f.dir  = vvf_pkg::DIR_W'(d);
                            f.kind = adj;
                            f.last = 1'b0;
                            found  = {found, f};
                        end
                    end
                    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
                    foreach (found[i]) pending_faces = {pending_faces, found[i]};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(input logic [vvf_pkg::ACT_W-1:0] act,
                                input logic [vvf_pkg::COORD_W-1:0] x, y, z,
                                input logic [vvf_pkg::DIR_W-1:0] pd,
                                input logic [vvf_pkg::KIND_W-1:0] kind);
        int gap;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_pos_x      <= x;
        s_pos_y      <= y;
        s_pos_z      <= z;
        s_plane_dir  <= pd;
        s_block_kind <= kind;
        do @(posedge aclk); while (!s_ready);
        track_request(act, x, y, z, pd, kind);
        sent_count++;
    endtask

    task automatic write_voxel(input logic [vvf_pkg::COORD_W-1:0] x, y, z,
                               input logic [vvf_pkg::KIND_W-1:0] kind);
        send_request(vvf_pkg::ACT_WR_VOXEL, x, y, z, vvf_pkg::DIR_W'($urandom_range(0, 7)), kind);
    endtask

    // the plane's own axis coordinate gets random junk
    task automatic write_plane(input int d, input logic [vvf_pkg::COORD_W-1:0] x, y, z,
                               input logic [vvf_pkg::KIND_W-1:0] kind);
        logic [vvf_pkg::COORD_W-1:0] junk;
        junk = vvf_pkg::COORD_W'($urandom_range(0, vvf_pkg::EDGE - 1));
        if (d < 2) send_request(vvf_pkg::ACT_WR_PLANE, x, junk, z, vvf_pkg::DIR_W'(d), kind);
        else if (d < 4) send_request(vvf_pkg::ACT_WR_PLANE, junk, y, z, vvf_pkg::DIR_W'(d), kind);
        else send_request(vvf_pkg::ACT_WR_PLANE, x, y, junk, vvf_pkg::DIR_W'(d), kind);
    endtask

    task automatic send_query(input logic [vvf_pkg::COORD_W-1:0] x, y, z);
        send_request(vvf_pkg::ACT_QUERY, x, y, z, vvf_pkg::DIR_W'($urandom_range(0, 7)),
                     vvf_pkg::KIND_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_faces.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [vvf_pkg::PRES_W-1:0] present,
                              input logic [vvf_pkg::KIND_W-1:0] air);
        cfg_we    <= 1'b1;
        cfg_index <= vvf_pkg::CFG_PRESENT;
        cfg_data  <= vvf_pkg::CFG_W'(present);
        @(posedge aclk);
        present_copy = present;
        cfg_index <= vvf_pkg::CFG_AIR;
        cfg_data  <= air;
        @(posedge aclk);
        air_copy = air;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [vvf_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return vvf_pkg::COORD_W'(vvf_pkg::EDGE - 1);
            default: return vvf_pkg::COORD_W'($urandom_range(0, vvf_pkg::EDGE - 1));
        endcase
    endfunction

    function automatic logic [vvf_pkg::KIND_W-1:0] pick_kind(input int air_pct);
        if ($urandom_range(0, 99) < air_pct) return air_copy;
        return vvf_pkg::KIND_W'($urandom_range(0, 255));
    endfunction

    // writes the spot and everything a query there may read, then queries it
    task automatic build_and_query(input logic [vvf_pkg::COORD_W-1:0] x, y, z);
        logic [vvf_pkg::COORD_W-1:0] nx;
        logic [vvf_pkg::COORD_W-1:0] ny;
        logic [vvf_pkg::COORD_W-1:0] nz;
        write_voxel(x, y, z, pick_kind(80));
        for (int d = 0; d < 6; d++) begin
            {nz, ny, nx} = neighbor_of(d, x, y, z);
            if (!vox_written[vox_slot(nx, ny, nz)] || $urandom_range(0, 3) == 0)
                write_voxel(nx, ny, nz, pick_kind(50));
        end
        for (int d = 0; d < 6; d++) begin
            if (!plane_written[plane_slot(d, x, y, z)] || $urandom_range(0, 3) == 0)
                write_plane(d, x, y, z, pick_kind(50));
        end
        send_query(x, y, z);
        safe_spots = {safe_spots, spot_t'({z, y, x})};
    endtask

    task automatic random_traffic(input int n);
        int                          target;
        int                          r;
        logic [vvf_pkg::COORD_W-1:0] x;
        logic [vvf_pkg::COORD_W-1:0] y;
        logic [vvf_pkg::COORD_W-1:0] z;
        target = sent_count + n;
        while (sent_count < target) begin
            r = $urandom_range(0, 99);
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            if (r < 55) begin
                build_and_query(x, y, z);
            end else if (r < 70) begin
                if (safe_spots.size() > 0) begin
                    {z, y, x} = safe_spots[$urandom_range(0, safe_spots.size() - 1)];
                    send_query(x, y, z);
                end else begin
                    build_and_query(x, y, z);
                end
            end else if (r < 80) begin
                write_voxel(x, y, z, pick_kind(40));
            end else if (r < 92) begin
                send_request(vvf_pkg::ACT_WR_PLANE, x, y, z,
                             vvf_pkg::DIR_W'($urandom_range(0, 7)), pick_kind(40));
            end else begin
                send_request(ACT_UNUSED, x, y, z, vvf_pkg::DIR_W'($urandom_range(0, 7)),
                             vvf_pkg::KIND_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // corner voxel with every neighbor opaque and every plane present
    task automatic test_corner_faces();
        logic [vvf_pkg::KIND_W-1:0]  vox_kinds [6] = '{8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
        logic [vvf_pkg::KIND_W-1:0]  pln_kinds [6] = '{8'h20, 8'h40, 8'h80, 8'h7F, 8'hFE, 8'h55};
        logic [vvf_pkg::COORD_W-1:0] nx;
        logic [vvf_pkg::COORD_W-1:0] ny;
        logic [vvf_pkg::COORD_W-1:0] nz;
        set_config(6'h3F, 8'h00);
        write_voxel(0, 0, 0, 8'h00);
        for (int d = 0; d < 6; d++) begin
            {nz, ny, nx} = neighbor_of(d, 0, 0, 0);
            write_voxel(nx, ny, nz, vox_kinds[d]);
        end
        for (int d = 0; d < 6; d++) write_plane(d, 0, 0, 0, pln_kinds[d]);
        send_query(0, 0, 0);
        safe_spots = {safe_spots, spot_t'(0)};
    endtask

    task automatic test_missing_neighbors();
        wait_drained();
        set_config(6'h00, 8'h00);
        send_query(0, 0, 0);
        wait_drained();
        set_config(6'b000100, 8'h00);
        send_query(0, 0, 0);
    endtask

    // opaque spot, unknown request, out-of-range plane selectors
    task automatic test_solid_and_ignored();
        wait_drained();
        set_config(6'h3F, 8'h00);
        write_voxel(0, 0, 0, 8'h5A);
        send_query(0, 0, 0);
        send_request(ACT_UNUSED, 0, 0, 0, vvf_pkg::DIR_NEG_Y, 8'h00);
        send_request(vvf_pkg::ACT_WR_PLANE, 0, 0, 0, PLANE_SEL_BAD_LO, 8'h00);
        send_request(vvf_pkg::ACT_WR_PLANE, 0, 0, 0, PLANE_SEL_BAD_HI, 8'h00);
        write_voxel(0, 0, 0, 8'h00);
        send_query(0, 0, 0);
    endtask

    task automatic test_air_code();
        wait_drained();
        set_config(6'h3F, 8'hFF);
        write_voxel(0, 0, 0, 8'hFF);
        send_query(0, 0, 0);
    endtask

    task automatic test_random_scenes();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        wait_drained();
        set_config(6'h3F, 8'h00);
        random_traffic(30);
        wait_drained();
        set_config(6'h00, 8'hFF);
        random_traffic(30);
        repeat (2) begin
            wait_drained();
            set_config(vvf_pkg::PRES_W'($urandom_range(0, 63)),
                       vvf_pkg::KIND_W'($urandom_range(0, 255)));
            random_traffic(30);
        end
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        logic [vvf_pkg::COORD_W-1:0] x;
        logic [vvf_pkg::COORD_W-1:0] y;
        logic [vvf_pkg::COORD_W-1:0] z;
        wait_drained();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        set_config(6'h3F, vvf_pkg::KIND_W'($urandom_range(0, 255)));
        hold_requests++;
        repeat (12) build_and_query(pick_coord(), pick_coord(), pick_coord());
        repeat (12) begin
            {z, y, x} = safe_spots[$urandom_range(0, safe_spots.size() - 1)];
            send_query(x, y, z);
        end
    endtask

    task automatic test_unthrottled_tail();
        wait_drained();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        set_config(vvf_pkg::PRES_W'($urandom_range(0, 63)),
                   vvf_pkg::KIND_W'($urandom_range(0, 255)));
        random_traffic(40);
    endtask

    // result side ready: random stall bursts plus the requested long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 15) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void compare_field(input string what,
                                          input logic [vvf_pkg::KIND_W-1:0] want,
                                          input logic [vvf_pkg::KIND_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        face_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_faces.size() == 0) begin
                $display("%0t: unexpected face, expected none, actual x=%0d y=%0d z=%0d dir=%0d",
                         $time, m_face_x, m_face_y, m_face_z, m_face_dir);
                fail_count++;
            end else begin
                want = pending_faces.pop_front();
                compare_field("face_x", vvf_pkg::KIND_W'(want.x), vvf_pkg::KIND_W'(m_face_x));
                compare_field("face_y", vvf_pkg::KIND_W'(want.y), vvf_pkg::KIND_W'(m_face_y));
                compare_field("face_z", vvf_pkg::KIND_W'(want.z), vvf_pkg::KIND_W'(m_face_z));
                compare_field("face_dir", vvf_pkg::KIND_W'(want.dir),
                              vvf_pkg::KIND_W'(m_face_dir));
                compare_field("facing_kind", want.kind, m_facing_kind);
                compare_field("last_face", vvf_pkg::KIND_W'(want.last),
                              vvf_pkg::KIND_W'(m_last_face));
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("voxel_visible_face_finder test failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_faces();
        test_missing_neighbors();
        test_solid_and_ignored();
        test_air_code();
        test_random_scenes();
        test_output_backpressure();
        test_unthrottled_tail();
        wait_drained();
        if (fail_count == 0) begin
            $display("voxel_visible_face_finder test passed");
        end else begin
            $display("voxel_visible_face_finder test failed");
        end
        $finish;
    end

endmodule
